// File: design/mnc_pkg.sv
// ============================================================================
// mnc_pkg: shared constants and types for the mine neighbor counter
// Sizes of the line store and positions, configuration register indexes,
// and the structs that link the sequencer with the line store and output.
// ============================================================================
`default_nettype none

package mnc_pkg;

    // Line store depth and derived address width
    localparam int MAX_WIDTH  = 32;
    localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Frame height limit and row position width
    localparam int MAX_HEIGHT = 1024;
    localparam int ROW_W      = 10;

    // Field widths
    localparam int WID_W      = 6;
    localparam int HGT_W      = 11;
    localparam int CNT_W      = 4;

    // Row slots in each line store word: older, middle, incoming
    localparam int NUM_SLOTS  = 3;
    localparam int SLOT_W     = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
    localparam logic [WID_W-1:0]     FRAME_WIDTH_RST  = 6'd32;
    localparam logic [HGT_W-1:0]     FRAME_HEIGHT_RST = 11'd1;

    // Request from the sequencer to the line store
    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             rd_ok;
        logic             flush_sel;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        logic             wr_bit;
        logic             rotate;
        logic             clear;
    } store_req_t;

    // One column of the 3x3 window, mapped to row roles
    typedef struct packed {
        logic above;
        logic middle;
        logic below;
    } rows_t;

    // Result beat handed to the output register
    typedef struct packed {
        logic             load;
        logic             is_mine;
        logic [CNT_W-1:0] count;
        logic             last;
        logic             eof;
    } result_t;

endpackage

`default_nettype wire

// File: design/mnc_line_store.sv
// ============================================================================
// mnc_line_store: three-row line store for the neighbor window
// One synchronous memory holds a bit per row slot and column. A slot pointer
// rotates row roles at each row end; per-slot valid bits make stale or
// never-written columns read as empty.
// ============================================================================
`default_nettype none

module mnc_line_store (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mnc_pkg::store_req_t req,
    output mnc_pkg::rows_t           rows
);

    logic [mnc_pkg::NUM_SLOTS-1:0] mem_reg [mnc_pkg::MAX_WIDTH];
    logic [mnc_pkg::NUM_SLOTS-1:0][mnc_pkg::MAX_WIDTH-1:0] vld_reg;
    logic [mnc_pkg::SLOT_W-1:0]    slot_reg;
    logic [mnc_pkg::SLOT_W-1:0]    slot_next;
    logic [mnc_pkg::NUM_SLOTS-1:0] rd_word_reg;
    logic [mnc_pkg::NUM_SLOTS-1:0] rd_vld_reg;
    logic                          rd_ok_reg;
    logic                          rd_flush_reg;
    logic [mnc_pkg::NUM_SLOTS-1:0] word;
    logic [mnc_pkg::SLOT_W-1:0]    inc_slot;
    logic [mnc_pkg::SLOT_W-1:0]    mid_slot;
    logic [mnc_pkg::SLOT_W-1:0]    old_slot;

    // Map row roles to slots: incoming at the pointer, then middle, then older
    always_comb
    begin
        inc_slot = slot_reg;
        mid_slot = (slot_reg == 2'd0) ? 2'd2 : slot_reg - 2'd1;
        old_slot = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
    end

    // Advance the pointer at a row end, return it home at frame end
    always_comb
    begin
        slot_next = slot_reg;
        if (req.clear)
        begin
            slot_next = '0;
        end
        else if (req.rotate)
        begin
            slot_next = old_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    // Track written columns per slot; drop a slot when it becomes incoming
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (req.clear)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (req.rotate)
            begin
                vld_reg[old_slot] <= '0;
            end
            if (req.wr_en)
            begin
                vld_reg[inc_slot][req.wr_addr] <= 1'b1;
            end
        end
    end

    // Write the incoming bit of one column
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr][inc_slot] <= req.wr_bit;
        end
    end

    // Register read data with its valid bits and qualifiers
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_word_reg  <= mem_reg[req.rd_addr];
            rd_vld_reg   <= {vld_reg[2][req.rd_addr], vld_reg[1][req.rd_addr],
                             vld_reg[0][req.rd_addr]};
            rd_ok_reg    <= req.rd_ok;
            rd_flush_reg <= req.flush_sel;
        end
    end

    // Mask stale bits and pick rows; the flush sees an empty row below
    always_comb
    begin
        word = rd_word_reg & rd_vld_reg & {mnc_pkg::NUM_SLOTS{rd_ok_reg}};
        if (rd_flush_reg)
        begin
            rows.above  = word[mid_slot];
            rows.middle = word[inc_slot];
            rows.below  = 1'b0;
        end
        else
        begin
            rows.above  = word[old_slot];
            rows.middle = word[mid_slot];
            rows.below  = word[inc_slot];
        end
    end

endmodule

`default_nettype wire

// File: design/mnc_sequencer.sv
// ============================================================================
// mnc_sequencer: position tracking and per-cell window sequencer
// Takes one cell, writes it to the line store, then for each reported cell
// reads the three window columns, sums the neighbors and hands a result beat
// to the output register. Updates row and column positions at item end.
// ============================================================================
`default_nettype none

module mnc_sequencer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        is_mine_in,
    input  wire logic [mnc_pkg::WID_W-1:0]   frame_width,
    input  wire logic [mnc_pkg::HGT_W-1:0]   frame_height,
    input  wire logic                        out_free,
    input  wire mnc_pkg::rows_t              rows,
    output logic                             in_stall,
    output mnc_pkg::store_req_t              req,
    output mnc_pkg::result_t                 res
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    localparam logic [2:0] K_LEFT   = 3'd0;
    localparam logic [2:0] K_CENTER = 3'd1;
    localparam logic [2:0] K_RIGHT  = 3'd2;
    localparam logic [2:0] K_LAST   = 3'd3;
    localparam logic [2:0] K_OUT    = 3'd4;

    logic                        state_reg, state_next;
    logic [2:0]                  k_reg, k_next;
    logic [mnc_pkg::COL_W-1:0]   col_pos_reg, col_pos_next;
    logic [mnc_pkg::ROW_W-1:0]   row_pos_reg, row_pos_next;
    logic                        in_flush_reg, in_flush_next;
    logic                        e2_pend_reg, e2_pend_next;
    logic                        fl_pend_reg, fl_pend_next;
    logic [mnc_pkg::COL_W-1:0]   x_reg, x_next;
    logic [mnc_pkg::WID_W-1:0]   w_reg, w_next;
    logic [mnc_pkg::COL_W-1:0]   c_reg, c_next;
    logic [mnc_pkg::ROW_W-1:0]   r_reg, r_next;
    logic                        row_end_reg, row_end_next;
    logic                        frame_end_reg, frame_end_next;
    logic [mnc_pkg::CNT_W-1:0]   sum_reg, sum_next;
    logic                        mine_reg, mine_next;

    logic [mnc_pkg::WID_W-1:0]   w_eff, wm1;
    logic [mnc_pkg::HGT_W-1:0]   h_eff, hm1;
    logic [mnc_pkg::COL_W-1:0]   c_cur;
    logic [mnc_pkg::ROW_W-1:0]   r_cur;
    logic                        row_end_cur, frame_end_cur;
    logic                        e1, e2, fl, start_any;
    logic                        accept, load, last_flush, done_all, fin;
    logic [mnc_pkg::COL_W-1:0]   fin_c;
    logic [mnc_pkg::ROW_W-1:0]   fin_r;
    logic                        fin_row_end, fin_frame_end;
    logic [mnc_pkg::WID_W-1:0]   rd_col;
    logic [1:0]                  add_val;
    logic                        above_bit;

    // Clamp the frame size and the positions to the frame in use
    always_comb
    begin
        if (frame_width == '0)
        begin
            w_eff = mnc_pkg::WID_W'(1);
        end
        else if (frame_width > mnc_pkg::WID_W'(mnc_pkg::MAX_WIDTH))
        begin
            w_eff = mnc_pkg::WID_W'(mnc_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = frame_width;
        end
        if (frame_height == '0)
        begin
            h_eff = mnc_pkg::HGT_W'(1);
        end
        else if (frame_height > mnc_pkg::HGT_W'(mnc_pkg::MAX_HEIGHT))
        begin
            h_eff = mnc_pkg::HGT_W'(mnc_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = frame_height;
        end
        wm1 = w_eff - mnc_pkg::WID_W'(1);
        hm1 = h_eff - mnc_pkg::HGT_W'(1);
        c_cur = (mnc_pkg::WID_W'(col_pos_reg) < wm1) ? col_pos_reg
                                                     : wm1[mnc_pkg::COL_W-1:0];
        r_cur = (mnc_pkg::HGT_W'(row_pos_reg) < hm1) ? row_pos_reg
                                                     : hm1[mnc_pkg::ROW_W-1:0];
        row_end_cur   = (mnc_pkg::WID_W'(c_cur) == wm1);
        frame_end_cur = row_end_cur && (mnc_pkg::HGT_W'(r_cur) == hm1);
    end

    // Decide which cells this beat reports
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign e1        = (r_cur != '0) && (c_cur != '0);
    assign e2        = (r_cur != '0) && row_end_cur;
    assign fl        = frame_end_cur;
    assign start_any = e1 || e2 || fl;
    assign in_stall  = (state_reg != ST_IDLE);

    // Result handoff and end of the item's work
    assign load       = (state_reg == ST_EMIT) && (k_reg == K_OUT) && out_free;
    assign last_flush = in_flush_reg && (mnc_pkg::WID_W'(x_reg) == w_reg - 1'b1);
    assign done_all   = in_flush_reg ? last_flush : (!e2_pend_reg && !fl_pend_reg);
    assign fin        = (accept && !start_any) || (load && done_all);

    assign fin_c         = accept ? c_cur : c_reg;
    assign fin_r         = accept ? r_cur : r_reg;
    assign fin_row_end   = accept ? row_end_cur : row_end_reg;
    assign fin_frame_end = accept ? frame_end_cur : frame_end_reg;

    // The flush of a frame ending in its first row sees an empty row above
    assign above_bit = rows.above && !(in_flush_reg && (r_reg == '0));

    // Issue window column reads, left to right around the cell
    always_comb
    begin
        rd_col        = mnc_pkg::WID_W'(x_reg) + mnc_pkg::WID_W'(k_reg) - 1'b1;
        req.rd_en     = (state_reg == ST_EMIT) && (k_reg <= K_RIGHT);
        req.rd_addr   = rd_col[mnc_pkg::COL_W-1:0];
        req.rd_ok     = !((k_reg == K_LEFT) && (x_reg == '0)) &&
                        !((k_reg == K_RIGHT) &&
                          (mnc_pkg::WID_W'(x_reg) == w_reg - 1'b1));
        req.flush_sel = in_flush_reg;
        req.wr_en     = accept;
        req.wr_addr   = c_cur;
        req.wr_bit    = is_mine_in;
        req.rotate    = fin && fin_row_end && !fin_frame_end;
        req.clear     = fin && fin_frame_end;
    end

    // Build the result beat
    always_comb
    begin
        res.load    = load;
        res.is_mine = mine_reg;
        res.count   = mine_reg ? '0 : sum_reg;
        res.last    = load && done_all;
        res.eof     = last_flush;
    end

    // Sequence the item: start jobs, accumulate columns, chain the next cell
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        in_flush_next  = in_flush_reg;
        e2_pend_next   = e2_pend_reg;
        fl_pend_next   = fl_pend_reg;
        x_next         = x_reg;
        w_next         = w_reg;
        c_next         = c_reg;
        r_next         = r_reg;
        row_end_next   = row_end_reg;
        frame_end_next = frame_end_reg;
        sum_next       = sum_reg;
        mine_next      = mine_reg;
        add_val        = 2'd0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && start_any)
                begin
                    state_next     = ST_EMIT;
                    k_next         = K_LEFT;
                    w_next         = w_eff;
                    c_next         = c_cur;
                    r_next         = r_cur;
                    row_end_next   = row_end_cur;
                    frame_end_next = frame_end_cur;
                    e2_pend_next   = e1 && e2;
                    fl_pend_next   = fl && (e1 || e2);
                    in_flush_next  = !e1 && !e2;
                    if (e1)
                    begin
                        x_next = c_cur - 1'b1;
                    end
                    else if (e2)
                    begin
                        x_next = wm1[mnc_pkg::COL_W-1:0];
                    end
                    else
                    begin
                        x_next = '0;
                    end
                end
            end
            ST_EMIT:
            begin
                // Accumulate the column that arrives this cycle
                if (k_reg == K_CENTER)
                begin
                    add_val = {1'b0, above_bit} + {1'b0, rows.middle} +
                              {1'b0, rows.below};
                end
                else if (k_reg == K_RIGHT)
                begin
                    add_val   = {1'b0, above_bit} + {1'b0, rows.below};
                    mine_next = rows.middle;
                end
                else if (k_reg == K_LAST)
                begin
                    add_val = {1'b0, above_bit} + {1'b0, rows.middle} +
                              {1'b0, rows.below};
                end

                if (k_reg == K_LEFT)
                begin
                    sum_next = '0;
                end
                else
                begin
                    sum_next = sum_reg + mnc_pkg::CNT_W'(add_val);
                end

                if (k_reg != K_OUT)
                begin
                    k_next = k_reg + 3'd1;
                end
                else if (load)
                begin
                    k_next = K_LEFT;
                    if (done_all)
                    begin
                        state_next    = ST_IDLE;
                        in_flush_next = 1'b0;
                    end
                    else if (in_flush_reg)
                    begin
                        x_next = x_reg + 1'b1;
                    end
                    else if (e2_pend_reg)
                    begin
                        e2_pend_next = 1'b0;
                        x_next       = mnc_pkg::COL_W'(w_reg - 1'b1);
                    end
                    else
                    begin
                        fl_pend_next  = 1'b0;
                        in_flush_next = 1'b1;
                        x_next        = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Move to the next cell, the next row, or back to the frame start
    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (fin)
        begin
            if (fin_frame_end)
            begin
                col_pos_next = '0;
                row_pos_next = '0;
            end
            else if (fin_row_end)
            begin
                col_pos_next = '0;
                row_pos_next = fin_r + 1'b1;
            end
            else
            begin
                col_pos_next = fin_c + 1'b1;
                row_pos_next = fin_r;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            k_reg        <= K_LEFT;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            in_flush_reg <= 1'b0;
            e2_pend_reg  <= 1'b0;
            fl_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            in_flush_reg <= in_flush_next;
            e2_pend_reg  <= e2_pend_next;
            fl_pend_reg  <= fl_pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        w_reg         <= w_next;
        c_reg         <= c_next;
        r_reg         <= r_next;
        row_end_reg   <= row_end_next;
        frame_end_reg <= frame_end_next;
        sum_reg       <= sum_next;
        mine_reg      <= mine_next;
    end

    // The frame-end flag only comes with the item's final beat
    a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.load && res.eof |-> res.last)
        else $error("end_of_frame without last_of_run");

    // The reported column stays inside the latched frame width
    a_x_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> mnc_pkg::WID_W'(x_reg) < w_reg)
        else $error("window column beyond frame width");

    // A frame end returns both positions to the origin
    a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
        req.clear |=> (col_pos_reg == '0) && (row_pos_reg == '0))
        else $error("positions not cleared at frame end");

    // A beat is only handed over when the output register can take it
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res.load |-> out_free)
        else $error("result loaded into a full output register");

endmodule

`default_nettype wire

// File: design/mine_neighbor_count_3x3_top.sv
// Each reported cell of an accepted beat runs window states LEFT, CENTER,
// RIGHT, LAST, OUT (held while the output register is full), then the output
// register. An item with no result ends when accepted; else in_stall holds the
// input until its last cell is handed over (three line store reads per cell on
// the single read port). A frame end flushes the whole last row. Reset (async,
// active low) clears positions, slot pointer and valid bits; no clearing pass.
// ============================================================================
// mine_neighbor_count_3x3_top: minesweeper neighbor counter, 3x3 window
// Takes a binary mine map one cell per beat in raster order and reports for
// each cell its mine mark or the number of mines among its eight neighbors.
// Holds the frame configuration and the output register.
// ============================================================================
`default_nettype none

module mine_neighbor_count_3x3_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [mnc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mnc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              is_mine_in,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   is_mine_out,
    output logic [mnc_pkg::CNT_W-1:0]              neighbor_count,
    output logic                                   last_of_run,
    output logic                                   end_of_frame
);

    logic [mnc_pkg::WID_W-1:0] frame_width_reg;
    logic [mnc_pkg::HGT_W-1:0] frame_height_reg;
    logic                      out_valid_reg;
    logic                      is_mine_reg;
    logic [mnc_pkg::CNT_W-1:0] count_reg;
    logic                      last_reg;
    logic                      eof_reg;
    logic                      out_free;
    mnc_pkg::store_req_t       req;
    mnc_pkg::rows_t            rows;
    mnc_pkg::result_t          res;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= mnc_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= mnc_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mnc_pkg::CFG_FRAME_WIDTH:
                begin
                    frame_width_reg <= cfg_data[mnc_pkg::WID_W-1:0];
                end
                mnc_pkg::CFG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= cfg_data;
                end
                default:
                begin
                    frame_height_reg <= frame_height_reg;
                end
            endcase
        end
    end

    mnc_sequencer u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .is_mine_in   (is_mine_in),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .out_free     (out_free),
        .rows         (rows),
        .in_stall     (in_stall),
        .req          (req),
        .res          (res)
    );

    mnc_line_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rows  (rows)
    );

    // Output register: free when empty or its beat is taken this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the result payload until the next load
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            is_mine_reg <= res.is_mine;
            count_reg   <= res.count;
            last_reg    <= res.last;
            eof_reg     <= res.eof;
        end
    end

    assign out_valid      = out_valid_reg;
    assign is_mine_out    = is_mine_reg;
    assign neighbor_count = count_reg;
    assign last_of_run    = last_reg;
    assign end_of_frame   = eof_reg;

endmodule

`default_nettype wire
